[design/circular_deque_defines.svh]
// assertion macros for the circular deque
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

`ifndef SYNTHESIS
`define CDQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CDQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define CDQ_ASSERT(label, prop, msg)
`define CDQ_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

[design/cdq_pkg.sv]
package cdq_pkg;

    localparam int COUNT_W   = 9;
    localparam int CAP_LIMIT = 256;
    localparam int OP_W      = 3;

    localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
    localparam logic [OP_W-1:0] OP_SWAP       = 3'd5;

    localparam logic [COUNT_W-1:0] CAP_RESET = 9'd256;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic               accepted;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [COUNT_W-1:0] occupancy;
        logic               is_empty;
        logic               is_full;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic swap_wr_front;
        logic swap_wr_next;
        logic fetch;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic swap_go;
    } status_t;

endpackage

[design/cdq_ctrl.sv]
`include "circular_deque_defines.svh"

module cdq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output cdq_pkg::cmd_t   cmd,
    input  cdq_pkg::status_t status
);
    import cdq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SWAP1  = 3'd2;
    localparam logic [2:0] S_SWAP2  = 3'd3;
    localparam logic [2:0] S_FETCH  = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = (state_reg != S_IDLE);
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.swap_go ? S_SWAP1 : S_FETCH;
            end
            S_SWAP1:
            begin
                cmd.swap_wr_front = 1'b1;
                state_next        = S_SWAP2;
            end
            S_SWAP2:
            begin
                cmd.swap_wr_next = 1'b1;
                state_next       = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `CDQ_ASSERT_NEXT(a_accept_to_exec, in_valid && !in_stall, state_reg == S_EXEC, "accepted word did not start execution")
    `CDQ_ASSERT(a_load_when_free, cmd.out_load |-> (!out_valid_reg || !out_stall), "result overwrote a pending word")
    `CDQ_ASSERT(a_swap_after_exec, (state_reg == S_SWAP1) |-> ($past(state_reg) == S_EXEC), "swap write without execute")

endmodule

[design/cdq_datapath.sv]
`include "circular_deque_defines.svh"

module cdq_datapath #(
    parameter int DEPTH     = 256,
    parameter int WORD_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [cdq_pkg::COUNT_W-1:0]   cfg_data,
    input  cdq_pkg::in_word_t             in_word,
    output cdq_pkg::out_word_t            out_word,
    input  cdq_pkg::cmd_t                 cmd,
    output cdq_pkg::status_t              status
);
    import cdq_pkg::*;

    localparam int MEM_DEPTH = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
    localparam int IDX_W     = $clog2(MEM_DEPTH);
    localparam logic [COUNT_W-1:0] CAP_MAX = COUNT_W'(MEM_DEPTH);

    logic [WORD_BITS-1:0] mem [MEM_DEPTH];

    logic [COUNT_W-1:0] capacity_reg, capacity_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [IDX_W-1:0]   back_reg, back_next;
    logic               acc_reg, acc_next;

    logic [OP_W-1:0]      op_reg;
    logic signed [31:0]   value_reg;
    logic [WORD_BITS-1:0] rd_a_reg;
    logic [WORD_BITS-1:0] rd_b_reg;
    out_word_t            out_word_reg;

    logic [COUNT_W-1:0] eff_cap;
    logic [COUNT_W-1:0] cap_m1;
    logic [COUNT_W-1:0] front_ext, front_inc, front_dec;
    logic [COUNT_W-1:0] back_ext, back_inc, back_dec;
    logic [IDX_W-1:0]   front_nxt, front_prv, back_nxt, back_prv;

    logic [WORD_BITS+31:0] wide_in;
    logic [WORD_BITS-1:0]  push_word;
    logic [WORD_BITS+31:0] wide_front;
    logic [WORD_BITS+31:0] wide_back;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr_a;
    logic [IDX_W-1:0]     rd_addr_b;
    out_word_t            result;

    // effective capacity and ring index arithmetic
    always_comb
    begin
        if (capacity_reg == '0)
            eff_cap = COUNT_W'(1);
        else if (capacity_reg > CAP_MAX)
            eff_cap = CAP_MAX;
        else
            eff_cap = capacity_reg;
        cap_m1    = eff_cap - COUNT_W'(1);
        front_ext = COUNT_W'(front_reg);
        back_ext  = COUNT_W'(back_reg);
        front_inc = front_ext + COUNT_W'(1);
        front_dec = front_ext - COUNT_W'(1);
        back_inc  = back_ext + COUNT_W'(1);
        back_dec  = back_ext - COUNT_W'(1);
        front_nxt = (front_inc >= eff_cap) ? '0 : front_inc[IDX_W-1:0];
        back_nxt  = (back_inc >= eff_cap) ? '0 : back_inc[IDX_W-1:0];
        front_prv = (front_ext == '0 || front_ext >= eff_cap) ? cap_m1[IDX_W-1:0]
                                                              : front_dec[IDX_W-1:0];
        back_prv  = (back_ext == '0 || back_ext >= eff_cap) ? cap_m1[IDX_W-1:0]
                                                            : back_dec[IDX_W-1:0];
    end

    assign wide_in        = {{WORD_BITS{1'b0}}, value_reg};
    assign push_word      = wide_in[WORD_BITS-1:0];
    assign status.swap_go = (op_reg == OP_SWAP) && (count_reg >= COUNT_W'(2));

    // index, count and write port control
    always_comb
    begin
        capacity_next = capacity_reg;
        count_next    = count_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        acc_next      = acc_reg;
        mem_we        = 1'b0;
        mem_waddr     = front_reg;
        mem_wdata     = push_word;
        if (cmd.exec)
        begin
            acc_next = 1'b0;
            case (op_reg)
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    if (count_reg < eff_cap)
                    begin
                        mem_we     = 1'b1;
                        acc_next   = 1'b1;
                        count_next = count_reg + COUNT_W'(1);
                        if (count_reg == '0)
                        begin
                            front_next = '0;
                            back_next  = '0;
                            mem_waddr  = '0;
                        end
                        else if (op_reg == OP_PUSH_FRONT)
                        begin
                            front_next = front_prv;
                            mem_waddr  = front_prv;
                        end
                        else
                        begin
                            back_next = back_nxt;
                            mem_waddr = back_nxt;
                        end
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    if (count_reg != '0)
                    begin
                        acc_next   = 1'b1;
                        count_next = count_reg - COUNT_W'(1);
                        if (count_reg > COUNT_W'(1))
                        begin
                            if (op_reg == OP_POP_FRONT)
                                front_next = front_nxt;
                            else
                                back_next = back_prv;
                        end
                    end
                end
                OP_SWAP:
                begin
                    acc_next = status.swap_go;
                end
                default:
                begin
                    acc_next = 1'b0;
                end
            endcase
        end
        if (cmd.swap_wr_front)
        begin
            mem_we    = 1'b1;
            mem_waddr = front_reg;
            mem_wdata = rd_b_reg;
        end
        if (cmd.swap_wr_next)
        begin
            mem_we    = 1'b1;
            mem_waddr = front_nxt;
            mem_wdata = rd_a_reg;
        end
        if (cfg_write)
        begin
            capacity_next = cfg_data;
            count_next    = '0;
            front_next    = '0;
            back_next     = '0;
        end
    end

    assign rd_en     = cmd.fetch || (cmd.exec && status.swap_go);
    assign rd_addr_a = front_reg;
    assign rd_addr_b = cmd.fetch ? back_reg : front_nxt;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            count_reg    <= '0;
            front_reg    <= '0;
            back_reg     <= '0;
            acc_reg      <= 1'b0;
        end
        else
        begin
            capacity_reg <= capacity_next;
            count_reg    <= count_next;
            front_reg    <= front_next;
            back_reg     <= back_next;
            acc_reg      <= acc_next;
        end
    end

    // result assembly
    assign wide_front = {32'b0, rd_a_reg};
    assign wide_back  = {32'b0, rd_b_reg};

    always_comb
    begin
        result.accepted    = acc_reg;
        result.front_value = (count_reg != '0) ? wide_front[31:0] : '0;
        result.back_value  = (count_reg != '0) ? wide_back[31:0] : '0;
        result.occupancy   = count_reg;
        result.is_empty    = (count_reg == '0);
        result.is_full     = (count_reg == eff_cap);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_word.operation;
            value_reg <= in_word.value;
        end
        if (cmd.out_load)
            out_word_reg <= result;
    end

    assign out_word = out_word_reg;

    `CDQ_ASSERT(a_count_in_cap, count_reg <= eff_cap, "occupancy above capacity")
    `CDQ_ASSERT(a_front_in_ring, (count_reg != '0) |-> (COUNT_W'(front_reg) < eff_cap), "front index outside ring")
    `CDQ_ASSERT(a_back_in_ring, (count_reg != '0) |-> (COUNT_W'(back_reg) < eff_cap), "back index outside ring")

endmodule

[design/circular_deque.sv]
// Double-ended queue of signed words held in a ring memory of up to 256 entries; the capacity
// register (reset 256, 0 acts as 1, larger values clip to the ring size) sets where the front
// and back indices wrap, and any write to it empties the deque. Each accepted word carries an
// operation and a value and returns one word with the accepted flag, front and back values,
// occupancy and empty and full flags. After acceptance a word passes through execute, a read
// of the front and back entries and the result state, where its result is loaded; a swap that
// takes effect adds a write of the front entry and a write of the entry after it before the read.
// These steps follow from the single write port and the registered read of the ring memory.
// A new word is accepted once the previous result is loaded, even while that result is still
// stalled at the output; the next result then waits until the output takes the old one.
module circular_deque #(
    parameter int DEPTH     = 256,
    parameter int WORD_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [cdq_pkg::COUNT_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  cdq_pkg::in_word_t           in_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cdq_pkg::out_word_t          out_word
);
    import cdq_pkg::*;

    cmd_t    cmd;
    status_t status;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    cdq_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .out_word  (out_word),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
